FILE: rtl/core/jsu_pkg.sv
// Package for the JSON string unescaper: scan modes, result group type,
// character codes and the hex digit decoder. No dependencies.
package jsu_pkg;

  typedef enum logic [2:0] {
    MODE_START = 3'd0,
    MODE_PLAIN = 3'd1,
    MODE_ESC   = 3'd2,
    MODE_HEX1  = 3'd3,
    MODE_HEX2  = 3'd4,
    MODE_HEX3  = 3'd5,
    MODE_HEX4  = 3'd6
  } jsu_mode_e;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5c;
  localparam logic [7:0] CH_N     = 8'h6e;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_U     = 8'h75;

  localparam logic [7:0] CODE_LF = 8'h0a;
  localparam logic [7:0] CODE_CR = 8'h0d;
  localparam logic [7:0] CODE_HT = 8'h09;
  localparam logic [7:0] CODE_BS = 8'h08;
  localparam logic [7:0] CODE_FF = 8'h0c;

  localparam logic [7:0] UTF_CONT  = 8'h80;
  localparam logic [7:0] UTF_LEAD2 = 8'hc0;
  localparam logic [7:0] UTF_LEAD3 = 8'he0;

  // Decoded bytes of one input beat, sent out one per cycle unless the output stalls.
  typedef struct packed {
    logic [1:0]      cnt;
    logic [7:0]      byte2;
    logic [7:0]      byte1;
    logic [7:0]      byte0;
    logic            str_end;
    logic            bad;
  } jsu_grp_t;

  // {valid, value}; non-hex digits give value zero.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/jsu_decode.sv
// Scan state and per-beat decode into a group of up to three bytes.
// Depends on jsu_pkg.
module jsu_decode import jsu_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] byte_i,
  input  logic       take_i,
  output jsu_grp_t   grp_o
);

  jsu_mode_e   mode_q, mode_d;
  logic [15:0] cp_q, cp_d;
  logic        err_q, err_d;
  logic [4:0]  hex;
  logic [15:0] cp_new;
  logic        err_new;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_START;
      cp_q   <= 16'd0;
      err_q  <= 1'b0;
    end else if (take_i) begin
      mode_q <= mode_d;
      cp_q   <= cp_d;
      err_q  <= err_d;
    end
  end

  assign hex     = hex_digit(byte_i);
  assign cp_new  = {cp_q[11:0], hex[3:0]};
  assign err_new = err_q | ~hex[4];

  always_comb begin
    mode_d = mode_q;
    cp_d   = cp_q;
    err_d  = err_q;
    grp_o  = '0;
    case (mode_q)
      MODE_ESC: begin
        mode_d    = MODE_PLAIN;
        grp_o.cnt = 2'd1;
        case (byte_i)
          CH_N:    grp_o.byte0 = CODE_LF;
          CH_R:    grp_o.byte0 = CODE_CR;
          CH_T:    grp_o.byte0 = CODE_HT;
          CH_B:    grp_o.byte0 = CODE_BS;
          CH_F:    grp_o.byte0 = CODE_FF;
          CH_U: begin
            grp_o.cnt = 2'd0;
            cp_d      = 16'd0;
            err_d     = 1'b0;
            mode_d    = MODE_HEX1;
          end
          default: grp_o.byte0 = byte_i;
        endcase
      end
      MODE_HEX1, MODE_HEX2, MODE_HEX3: begin
        cp_d  = cp_new;
        err_d = err_new;
        case (mode_q)
          MODE_HEX1: mode_d = MODE_HEX2;
          MODE_HEX2: mode_d = MODE_HEX3;
          default:   mode_d = MODE_HEX4;
        endcase
      end
      MODE_HEX4: begin
        cp_d      = cp_new;
        err_d     = err_new;
        mode_d    = MODE_PLAIN;
        grp_o.bad = err_new;
        if (cp_new[15:7] == 9'd0) begin
          grp_o.cnt   = 2'd1;
          grp_o.byte0 = cp_new[7:0];
        end else if (cp_new[15:11] == 5'd0) begin
          grp_o.cnt   = 2'd2;
          grp_o.byte0 = UTF_LEAD2 | {3'd0, cp_new[10:6]};
          grp_o.byte1 = UTF_CONT | {2'd0, cp_new[5:0]};
        end else begin
          grp_o.cnt   = 2'd3;
          grp_o.byte0 = UTF_LEAD3 | {4'd0, cp_new[15:12]};
          grp_o.byte1 = UTF_CONT | {2'd0, cp_new[11:6]};
          grp_o.byte2 = UTF_CONT | {2'd0, cp_new[5:0]};
        end
      end
      default: begin
        if (mode_q == MODE_START && byte_i == CH_QUOTE) begin
          mode_d = MODE_PLAIN;
        end else if (byte_i == CH_QUOTE) begin
          grp_o.cnt     = 2'd1;
          grp_o.str_end = 1'b1;
          mode_d        = MODE_START;
          cp_d          = 16'd0;
          err_d         = 1'b0;
        end else if (byte_i == CH_BSL) begin
          mode_d = MODE_ESC;
        end else begin
          grp_o.cnt   = 2'd1;
          grp_o.byte0 = byte_i;
          mode_d      = MODE_PLAIN;
        end
      end
    endcase
  end

endmodule

FILE: rtl/core/jsu_serial.sv
// Result register: holds one decoded group and sends its bytes as beats.
// Depends on jsu_pkg.
module jsu_serial import jsu_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       load_i,
  input  jsu_grp_t   grp_i,
  output logic       free_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       string_end_o,
  output logic       last_o,
  output logic       bad_hex_o
);

  logic     vld_q;
  logic [1:0] idx_q;
  jsu_grp_t grp_q;
  logic     last;

  assign last   = (idx_q == grp_q.cnt - 2'd1);
  assign free_o = !vld_q || (!out_stall_i && last);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      idx_q <= 2'd0;
    end else if (load_i) begin
      vld_q <= 1'b1;
      idx_q <= 2'd0;
    end else if (vld_q && !out_stall_i) begin
      if (last) begin
        vld_q <= 1'b0;
      end else begin
        idx_q <= idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      grp_q <= grp_i;
    end
  end

  always_comb begin
    case (idx_q)
      2'd0:    out_byte_o = grp_q.byte0;
      2'd1:    out_byte_o = grp_q.byte1;
      default: out_byte_o = grp_q.byte2;
    endcase
  end

  assign out_valid_o  = vld_q;
  assign string_end_o = grp_q.str_end;
  assign last_o       = last;
  assign bad_hex_o    = grp_q.bad;

endmodule

FILE: rtl/core/json_string_unescape_utf8.sv
// JSON string unescaper: one raw string byte per beat in, decoded UTF-8 bytes out.
// The accepted input byte is registered, then decoded into the result register.
// Throughput: one input beat per cycle unless stalled; a \u escape sends up to three
// result beats, one per cycle unless stalled, stalling input beats that give output.
// Reset: asynchronous, active low; scan state returns to string start, pipeline empties.
// Depends on jsu_pkg, jsu_decode, jsu_serial.
module json_string_unescape_utf8 import jsu_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       string_end_o,
  output logic       last_o,
  output logic       bad_hex_o
);

  logic       in_vld_q;
  logic [7:0] in_byte_q;
  jsu_grp_t   grp;
  logic       free;
  logic       take;

  assign take       = in_vld_q && (grp.cnt == 2'd0 || free);
  assign in_stall_o = in_vld_q && !take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_byte_q <= in_byte_i;
    end
  end

  jsu_decode u_decode (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .byte_i (in_byte_q),
    .take_i (take),
    .grp_o  (grp)
  );

  jsu_serial u_serial (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (take && grp.cnt != 2'd0),
    .grp_i        (grp),
    .free_o       (free),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_byte_o   (out_byte_o),
    .string_end_o (string_end_o),
    .last_o       (last_o),
    .bad_hex_o    (bad_hex_o)
  );

endmodule

FILE: rtl/core/jsu_checker.sv
// Port-level checks for the JSON string unescaper, bound to the top level.
// Depends on json_string_unescape_utf8 ports only.
module jsu_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] out_byte_o,
  input logic       string_end_o,
  input logic       last_o,
  input logic       bad_hex_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_byte_o))
    else $error("stalled result beat changed");

  a_end_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && string_end_o |-> last_o && out_byte_o == 8'd0)
    else $error("terminator beat not last or not zero");

  a_end_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && string_end_o |-> !bad_hex_o)
    else $error("terminator beat flagged bad hex");

  a_group_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o && !out_stall_i |=> out_valid_o && !string_end_o)
    else $error("multi-byte group broken off");

endmodule

bind json_string_unescape_utf8 jsu_checker u_jsu_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .out_byte_o   (out_byte_o),
  .string_end_o (string_end_o),
  .last_o       (last_o),
  .bad_hex_o    (bad_hex_o)
);

FILE: sim/json_string_unescape_utf8_test.sv
`timescale 1ns / 1ps
// Testbench for json_string_unescape_utf8: quoted string bytes in, decoded bytes out,
// checked beat by beat against a predictor of the unescaper; needs it and jsu_pkg.
module json_string_unescape_utf8_test import jsu_pkg::*; ();

  localparam int TOTAL_BYTES    = 370;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 20;
  localparam int QUIET_TAIL     = 40;

  typedef struct packed {
    logic [7:0] data;
    logic       str_end;
    logic       last;
    logic       bad;
  } dec_beat_t;

  logic       clk_i        = 1'b0;
  logic       rst_ni       = 1'b0;
  logic       in_valid_i   = 1'b0;
  logic [7:0] in_byte_i    = 8'd0;
  logic       out_stall_i  = 1'b0;
  logic       in_stall_o;
  logic       out_valid_o;
  logic [7:0] out_byte_o;
  logic       string_end_o;
  logic       last_o;
  logic       bad_hex_o;

  logic [7:0] raw_stream[$];
  dec_beat_t  expected_bytes[$];

  jsu_mode_e   scan_mode  = MODE_START;
  logic [15:0] code_acc   = 16'd0;
  logic        hex_seen_bad = 1'b0;

  bit running   = 1'b0;
  bit in_taken  = 1'b0;
  bit out_taken = 1'b0;
  int in_gap    = 0;
  int out_gap   = 0;
  int idle_cycles = 0;
  int mismatches  = 0;

  json_string_unescape_utf8 i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_byte_i   (in_byte_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o),
    .string_end_o(string_end_o),
    .last_o      (last_o),
    .bad_hex_o   (bad_hex_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic dec_beat_t mk_beat(input logic [7:0] data, input logic str_end,
                                        input logic bad);
    dec_beat_t b;
    b.data    = data;
    b.str_end = str_end;
    b.last    = 1'b0;
    b.bad     = bad;
    return b;
  endfunction

  function automatic bit hex_nibble(input logic [7:0] c, output logic [3:0] v);
    v = 4'd0;
    if (c >= "0" && c <= "9") begin
      v = 4'(c - "0");
      return 1'b1;
    end
    if (c >= "a" && c <= "f") begin
      v = 4'(c - "a" + 8'd10);
      return 1'b1;
    end
    if (c >= "A" && c <= "F") begin
      v = 4'(c - "A" + 8'd10);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n, input bit upper);
    if (n < 4'd10) return "0" + n;
    return (upper ? "A" : "a") + n - 8'd10;
  endfunction

  task automatic unescape_byte(input logic [7:0] c);
    dec_beat_t   outs[$];
    logic [3:0]  nib;
    logic [15:0] cp;
    bit          ok;
    if (scan_mode == MODE_START && c == CH_QUOTE) begin
      scan_mode = MODE_PLAIN;
    end else if (scan_mode == MODE_ESC) begin
      scan_mode = MODE_PLAIN;
      case (c)
        CH_N: outs.push_back(mk_beat(CODE_LF, 1'b0, 1'b0));
        CH_R: outs.push_back(mk_beat(CODE_CR, 1'b0, 1'b0));
        CH_T: outs.push_back(mk_beat(CODE_HT, 1'b0, 1'b0));
        CH_B: outs.push_back(mk_beat(CODE_BS, 1'b0, 1'b0));
        CH_F: outs.push_back(mk_beat(CODE_FF, 1'b0, 1'b0));
        CH_U: begin
          code_acc     = 16'd0;
          hex_seen_bad = 1'b0;
          scan_mode    = MODE_HEX1;
        end
        default: outs.push_back(mk_beat(c, 1'b0, 1'b0));
      endcase
    end else if (scan_mode inside {[MODE_HEX1:MODE_HEX4]}) begin
      ok = hex_nibble(c, nib);
      if (!ok) hex_seen_bad = 1'b1;
      code_acc = {code_acc[11:0], nib};
      if (scan_mode != MODE_HEX4) begin
        scan_mode = jsu_mode_e'(scan_mode + 3'd1);
      end else begin
        scan_mode = MODE_PLAIN;
        cp = code_acc;
        if (cp < 16'h0080) begin
          outs.push_back(mk_beat(cp[7:0], 1'b0, hex_seen_bad));
        end else if (cp < 16'h0800) begin
          outs.push_back(mk_beat(UTF_LEAD2 | {3'b000, cp[10:6]}, 1'b0, hex_seen_bad));
          outs.push_back(mk_beat(UTF_CONT | {2'b00, cp[5:0]}, 1'b0, hex_seen_bad));
        end else begin
          outs.push_back(mk_beat(UTF_LEAD3 | {4'b0000, cp[15:12]}, 1'b0, hex_seen_bad));
          outs.push_back(mk_beat(UTF_CONT | {2'b00, cp[11:6]}, 1'b0, hex_seen_bad));
          outs.push_back(mk_beat(UTF_CONT | {2'b00, cp[5:0]}, 1'b0, hex_seen_bad));
        end
      end
    end else if (c == CH_QUOTE) begin
      outs.push_back(mk_beat(8'd0, 1'b1, 1'b0));
      scan_mode    = MODE_START;
      code_acc     = 16'd0;
      hex_seen_bad = 1'b0;
    end else if (c == CH_BSL) begin
      scan_mode = MODE_ESC;
    end else begin
      outs.push_back(mk_beat(c, 1'b0, 1'b0));
      scan_mode = MODE_PLAIN;
    end
    if (outs.size() > 0) outs[outs.size() - 1].last = 1'b1;
    foreach (outs[k]) expected_bytes.push_back(outs[k]);
  endtask

  task automatic flag_mismatch(input string msg);
    if (mismatches < 40) $display("MISMATCH @%0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic push_uescape(input logic [15:0] cp, input bit corrupt);
    int         bad_pos;
    logic [7:0] c;
    bad_pos = corrupt ? int'($urandom_range(0, 3)) : -1;
    raw_stream.push_back(CH_BSL);
    raw_stream.push_back(CH_U);
    for (int k = 3; k >= 0; k--) begin
      c = hex_char(cp[4*k +: 4], 1'($urandom_range(0, 1)));
      if (3 - k == bad_pos) begin
        do c = 8'($urandom_range(0, 255));
        while (c inside {["0":"9"], ["a":"f"], ["A":"F"]});
      end
      raw_stream.push_back(c);
    end
  endtask

  task automatic push_random_string();
    logic [7:0] esc_set[8];
    logic [7:0] c;
    logic [15:0] cp;
    int n;
    esc_set = '{CH_N, CH_R, CH_T, CH_B, CH_F, CH_QUOTE, CH_BSL, "/"};
    if ($urandom_range(0, 9) != 0) raw_stream.push_back(CH_QUOTE);
    n = $urandom_range(0, 8);
    repeat (n) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: begin
          do c = 8'($urandom_range(0, 255)); while (c == CH_QUOTE || c == CH_BSL);
          raw_stream.push_back(c);
        end
        5, 6: begin
          raw_stream.push_back(CH_BSL);
          if ($urandom_range(0, 8) == 8) raw_stream.push_back(8'($urandom_range(0, 255)));
          else raw_stream.push_back(esc_set[$urandom_range(0, 7)]);
        end
        default: begin
          case ($urandom_range(0, 3))
            0: cp = 16'($urandom_range(16'h0000, 16'h007f));
            1: cp = 16'($urandom_range(16'h0080, 16'h07ff));
            2: cp = 16'($urandom_range(16'h0800, 16'hffff));
            default: cp = 16'($urandom_range(0, 16'hffff));
          endcase
          push_uescape(cp, $urandom_range(0, 4) == 0);
        end
      endcase
    end
    if ($urandom_range(0, 9) != 0) raw_stream.push_back(CH_QUOTE);
  endtask

  // driver
  always @(negedge clk_i) begin
    if (running) begin
      if (!in_valid_i || in_taken) begin
        if (in_gap > 0) begin
          in_valid_i <= 1'b0;
          in_gap--;
        end else if (raw_stream.size() == 0) begin
          in_valid_i <= 1'b0;
        end else if (raw_stream.size() > QUIET_TAIL && $urandom_range(0, 7) == 0) begin
          in_valid_i <= 1'b0;
          in_gap = $urandom_range(0, 4);
        end else begin
          in_valid_i <= 1'b1;
          in_byte_i  <= raw_stream.pop_front();
        end
      end
      if (out_gap > 0) begin
        out_stall_i <= 1'b1;
        out_gap--;
      end else if (raw_stream.size() > QUIET_TAIL && $urandom_range(0, 7) == 0) begin
        out_stall_i <= 1'b1;
        out_gap = $urandom_range(0, 4);
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // monitor and watchdog
  always @(posedge clk_i) begin
    dec_beat_t want;
    if (running) begin
      in_taken  = in_valid_i && !in_stall_o;
      out_taken = out_valid_o && !out_stall_i;
      if (in_taken) unescape_byte(in_byte_i);
      if (out_taken) begin
        if (expected_bytes.size() == 0) begin
          flag_mismatch($sformatf("unexpected beat byte=%02h end=%0b", out_byte_o,
                                  string_end_o));
        end else begin
          want = expected_bytes.pop_front();
          if (out_byte_o !== want.data)
            flag_mismatch($sformatf("out_byte %02h, want %02h", out_byte_o, want.data));
          if (string_end_o !== want.str_end)
            flag_mismatch($sformatf("string_end %0b, want %0b", string_end_o, want.str_end));
          if (last_o !== want.last)
            flag_mismatch($sformatf("last %0b, want %0b", last_o, want.last));
          if (bad_hex_o !== want.bad)
            flag_mismatch($sformatf("bad_hex %0b, want %0b", bad_hex_o, want.bad));
        end
      end
      idle_cycles = (in_taken || out_taken) ? 0 : idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    raw_stream = '{CH_QUOTE, CH_QUOTE,
                   CH_BSL, CH_T, 8'h00, 8'hff,
                   CH_BSL, CH_N, CH_BSL, CH_R, CH_BSL, CH_B, CH_BSL, CH_F};
    push_uescape(16'hffff, 1'b0);
    raw_stream.push_back(CH_BSL);
    raw_stream.push_back(CH_U);
    raw_stream.push_back(CH_QUOTE);
    raw_stream.push_back("7");
    raw_stream.push_back("f");
    raw_stream.push_back("F");
    raw_stream.push_back(CH_QUOTE);
    while (raw_stream.size() < TOTAL_BYTES) begin
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 4)) raw_stream.push_back(8'($urandom_range(0, 255)));
      end else begin
        push_random_string();
      end
    end
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    running = 1'b1;
    while (raw_stream.size() > 0 || in_valid_i || expected_bytes.size() > 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && expected_bytes.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
